// File: rtl/segint_pkg.sv
// segint_pkg: payload types and widths for the segment intersection block
package segint_pkg;

    localparam int COORD_WIDTH = 24;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] seg1_start_x;
        logic signed [COORD_WIDTH-1:0] seg1_start_y;
        logic signed [COORD_WIDTH-1:0] seg1_end_x;
        logic signed [COORD_WIDTH-1:0] seg1_end_y;
        logic signed [COORD_WIDTH-1:0] seg2_start_x;
        logic signed [COORD_WIDTH-1:0] seg2_start_y;
        logic signed [COORD_WIDTH-1:0] seg2_end_x;
        logic signed [COORD_WIDTH-1:0] seg2_end_y;
    } segint_in_t;

    typedef struct packed {
        logic                          hit;
        logic signed [COORD_WIDTH-1:0] cross_x;
        logic signed [COORD_WIDTH-1:0] cross_y;
    } segint_out_t;

endpackage

// File: rtl/segment_intersection.sv
// segment_intersection: pipelined proper-crossing test and crossing point of two segments
// pipeline: 5 arithmetic stages, one magnitude stage, 25 restoring divider stages at one
// quotient bit each, then an output register
// throughput: one transaction per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, so a stall holds every stage in place
// reset: synchronous active-low aresetn clears all stage valid bits; data is not reset
module segment_intersection (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  segint_pkg::segint_in_t   s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output segint_pkg::segint_out_t  m_data
);
    import segint_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int D  = W + 1;        // coordinate difference
    localparam int P  = 2 * D;        // product of differences
    localparam int C  = P + 1;        // cross product
    localparam int L  = C / 2;        // low split of num for the wide multiply
    localparam int PL = L + 1 + D;
    localparam int PH = C - L + D;
    localparam int N  = C + D;        // num * f
    localparam int Q  = D;            // quotient bits

    function automatic logic signed [D-1:0] dif(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        dif = D'(a) - D'(b);
    endfunction

    function automatic logic signed [P-1:0] mul(input logic signed [D-1:0] a,
                                                 input logic signed [D-1:0] b);
        mul = P'(a) * P'(b);
    endfunction

    logic en;

    // stage 1: differences
    logic                v1_reg;
    logic signed [D-1:0] dv_reg [18];
    logic signed [W-1:0] bx1_reg, by1_reg;

    // stage 2: products
    logic                v2_reg;
    logic signed [P-1:0] prod_reg [12];
    logic signed [D-1:0] fx2_reg, fy2_reg;
    logic signed [W-1:0] bx2_reg, by2_reg;

    // stage 3: cross products and hit decision
    logic                v3_reg, hit3_reg;
    logic signed [C-1:0] num3_reg, den3_reg;
    logic signed [D-1:0] fx3_reg, fy3_reg;
    logic signed [W-1:0] bx3_reg, by3_reg;
    logic signed [C-1:0] crs [6];
    logic [3:0]          onz, oneg;

    // stage 4: partial products
    logic                 v4_reg, hit4_reg;
    logic signed [PL-1:0] pplx_reg, pply_reg;
    logic signed [PH-1:0] pphx_reg, pphy_reg;
    logic signed [C-1:0]  den4_reg;
    logic signed [W-1:0]  bx4_reg, by4_reg;

    // stage 5: full dividends
    logic                v5_reg, hit5_reg;
    logic signed [N-1:0] nx5_reg, ny5_reg;
    logic signed [C-1:0] den5_reg;
    logic signed [W-1:0] bx5_reg, by5_reg;

    // divider stages, index 0 holds magnitudes
    logic                vd_reg   [Q+1];
    logic                hitd_reg [Q+1];
    logic [N-1:0]        remx_reg [Q+1];
    logic [N-1:0]        remy_reg [Q+1];
    logic [Q-1:0]        qx_reg   [Q+1];
    logic [Q-1:0]        qy_reg   [Q+1];
    logic                negx_reg [Q+1];
    logic                negy_reg [Q+1];
    logic [C-1:0]        dm_reg   [Q+1];
    logic signed [W-1:0] bxd_reg  [Q+1];
    logic signed [W-1:0] byd_reg  [Q+1];
    logic [N-1:0]        remx_next [Q+1];
    logic [N-1:0]        remy_next [Q+1];
    logic [Q-1:0]        qx_next   [Q+1];
    logic [Q-1:0]        qy_next   [Q+1];

    logic signed [D:0]   qsx, qsy;

    segint_out_t out_reg;
    logic        m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            crs[k] = C'(prod_reg[2*k]) - C'(prod_reg[2*k+1]);
        end
        for (int k = 0; k < 4; k++) begin
            onz[k]  = (crs[k] != '0);
            oneg[k] = crs[k][C-1];
        end
    end

    // one quotient bit per stage
    always_comb begin
        remx_next[0] = '0;
        remy_next[0] = '0;
        qx_next[0]   = '0;
        qy_next[0]   = '0;
        for (int k = 0; k < Q; k++) begin
            remx_next[k+1] = remx_reg[k];
            remy_next[k+1] = remy_reg[k];
            qx_next[k+1]   = qx_reg[k];
            qy_next[k+1]   = qy_reg[k];
            if (remx_reg[k] >= (N'(dm_reg[k]) << (Q-1-k))) begin
                remx_next[k+1]        = remx_reg[k] - (N'(dm_reg[k]) << (Q-1-k));
                qx_next[k+1][Q-1-k]   = 1'b1;
            end
            if (remy_reg[k] >= (N'(dm_reg[k]) << (Q-1-k))) begin
                remy_next[k+1]        = remy_reg[k] - (N'(dm_reg[k]) << (Q-1-k));
                qy_next[k+1][Q-1-k]   = 1'b1;
            end
        end
    end

    // floor correction for a negative quotient
    always_comb begin
        qsx = $signed({1'b0, qx_reg[Q]});
        qsy = $signed({1'b0, qy_reg[Q]});
        if (negx_reg[Q]) begin
            qsx = -qsx - (D+1)'(remx_reg[Q] != '0);
        end
        if (negy_reg[Q]) begin
            qsy = -qsy - (D+1)'(remy_reg[Q] != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k <= Q; k++) begin
                vd_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            vd_reg[0]   <= v5_reg;
            for (int k = 0; k < Q; k++) begin
                vd_reg[k+1] <= vd_reg[k];
            end
            m_valid_reg <= vd_reg[Q];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1
            dv_reg[0]  <= dif(s_data.seg1_end_x,   s_data.seg1_start_x);
            dv_reg[1]  <= dif(s_data.seg1_end_y,   s_data.seg1_start_y);
            dv_reg[2]  <= dif(s_data.seg2_start_x, s_data.seg1_start_x);
            dv_reg[3]  <= dif(s_data.seg2_start_y, s_data.seg1_start_y);
            dv_reg[4]  <= dif(s_data.seg2_end_x,   s_data.seg1_start_x);
            dv_reg[5]  <= dif(s_data.seg2_end_y,   s_data.seg1_start_y);
            dv_reg[6]  <= dif(s_data.seg2_end_x,   s_data.seg2_start_x);
            dv_reg[7]  <= dif(s_data.seg2_end_y,   s_data.seg2_start_y);
            dv_reg[8]  <= dif(s_data.seg1_start_x, s_data.seg2_start_x);
            dv_reg[9]  <= dif(s_data.seg1_start_y, s_data.seg2_start_y);
            dv_reg[10] <= dif(s_data.seg1_end_x,   s_data.seg2_start_x);
            dv_reg[11] <= dif(s_data.seg1_end_y,   s_data.seg2_start_y);
            dv_reg[12] <= dif(s_data.seg2_end_x,   s_data.seg1_end_x);
            dv_reg[13] <= dif(s_data.seg2_end_y,   s_data.seg1_end_y);
            dv_reg[14] <= dif(s_data.seg2_start_x, s_data.seg2_end_x);
            dv_reg[15] <= dif(s_data.seg2_start_y, s_data.seg2_end_y);
            dv_reg[16] <= dif(s_data.seg1_start_x, s_data.seg1_end_x);
            dv_reg[17] <= dif(s_data.seg1_start_y, s_data.seg1_end_y);
            bx1_reg    <= s_data.seg1_end_x;
            by1_reg    <= s_data.seg1_end_y;

            // stage 2: orientation, num and den products
            prod_reg[0]  <= mul(dv_reg[0],  dv_reg[3]);
            prod_reg[1]  <= mul(dv_reg[1],  dv_reg[2]);
            prod_reg[2]  <= mul(dv_reg[0],  dv_reg[5]);
            prod_reg[3]  <= mul(dv_reg[1],  dv_reg[4]);
            prod_reg[4]  <= mul(dv_reg[6],  dv_reg[9]);
            prod_reg[5]  <= mul(dv_reg[7],  dv_reg[8]);
            prod_reg[6]  <= mul(dv_reg[6],  dv_reg[11]);
            prod_reg[7]  <= mul(dv_reg[7],  dv_reg[10]);
            prod_reg[8]  <= mul(dv_reg[12], dv_reg[15]);
            prod_reg[9]  <= mul(dv_reg[13], dv_reg[14]);
            prod_reg[10] <= mul(dv_reg[16], dv_reg[15]);
            prod_reg[11] <= mul(dv_reg[17], dv_reg[14]);
            fx2_reg <= dv_reg[16];
            fy2_reg <= dv_reg[17];
            bx2_reg <= bx1_reg;
            by2_reg <= by1_reg;

            // stage 3: each segment must strictly straddle the other's line
            hit3_reg <= &onz && (oneg[0] ^ oneg[1]) && (oneg[2] ^ oneg[3]);
            num3_reg <= crs[4];
            den3_reg <= crs[5];
            fx3_reg  <= fx2_reg;
            fy3_reg  <= fy2_reg;
            bx3_reg  <= bx2_reg;
            by3_reg  <= by2_reg;

            // stage 4: num split into unsigned low and signed high halves
            pplx_reg <= PL'($signed({1'b0, num3_reg[L-1:0]})) * PL'(fx3_reg);
            pply_reg <= PL'($signed({1'b0, num3_reg[L-1:0]})) * PL'(fy3_reg);
            pphx_reg <= PH'($signed(num3_reg[C-1:L])) * PH'(fx3_reg);
            pphy_reg <= PH'($signed(num3_reg[C-1:L])) * PH'(fy3_reg);
            hit4_reg <= hit3_reg;
            den4_reg <= den3_reg;
            bx4_reg  <= bx3_reg;
            by4_reg  <= by3_reg;

            // stage 5
            nx5_reg  <= (N'(pphx_reg) <<< L) + N'(pplx_reg);
            ny5_reg  <= (N'(pphy_reg) <<< L) + N'(pply_reg);
            hit5_reg <= hit4_reg;
            den5_reg <= den4_reg;
            bx5_reg  <= bx4_reg;
            by5_reg  <= by4_reg;

            // divider entry: magnitudes and quotient signs
            remx_reg[0] <= nx5_reg[N-1] ? N'(-nx5_reg) : N'(nx5_reg);
            remy_reg[0] <= ny5_reg[N-1] ? N'(-ny5_reg) : N'(ny5_reg);
            dm_reg[0]   <= den5_reg[C-1] ? C'(-den5_reg) : C'(den5_reg);
            negx_reg[0] <= nx5_reg[N-1] ^ den5_reg[C-1];
            negy_reg[0] <= ny5_reg[N-1] ^ den5_reg[C-1];
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            hitd_reg[0] <= hit5_reg;
            bxd_reg[0]  <= bx5_reg;
            byd_reg[0]  <= by5_reg;
            for (int k = 0; k < Q; k++) begin
                remx_reg[k+1] <= remx_next[k+1];
                remy_reg[k+1] <= remy_next[k+1];
                qx_reg[k+1]   <= qx_next[k+1];
                qy_reg[k+1]   <= qy_next[k+1];
                dm_reg[k+1]   <= dm_reg[k];
                negx_reg[k+1] <= negx_reg[k];
                negy_reg[k+1] <= negy_reg[k];
                hitd_reg[k+1] <= hitd_reg[k];
                bxd_reg[k+1]  <= bxd_reg[k];
                byd_reg[k+1]  <= byd_reg[k];
            end

            // output
            out_reg.hit <= hitd_reg[Q];
            if (hitd_reg[Q]) begin
                out_reg.cross_x <= bxd_reg[Q] + qsx[W-1:0];
                out_reg.cross_y <= byd_reg[Q] + qsy[W-1:0];
            end else begin
                out_reg.cross_x <= '0;
                out_reg.cross_y <= '0;
            end
        end
    end

`ifndef SYNTHESIS
    // no-hit transactions carry zero coordinates
    a_nohit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.hit |-> m_data.cross_x == '0 && m_data.cross_y == '0)
        else $error("no-hit result with nonzero coordinates");

    // a proper crossing never has a zero divisor
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        vd_reg[0] && hitd_reg[0] |-> dm_reg[0] != '0)
        else $error("zero divisor on a hit");

    // final remainders stay below the divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vd_reg[Q] && hitd_reg[Q] |-> remx_reg[Q] < N'(dm_reg[Q]) &&
                                     remy_reg[Q] < N'(dm_reg[Q]))
        else $error("divider remainder out of range");

    // nothing leaves the pipeline straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("output valid after reset");
`endif

endmodule

// File: verif/testbench.sv
// testbench for the segment intersection block: directed and random segment pairs
`timescale 1ns / 100ps

module testbench;
    import segint_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int LATENCY = 32;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    segint_in_t  s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    segint_out_t m_data;

    segint_out_t crossing_queue[$];
    int          mismatches = 0;
    bit          rx_hold = 1'b0;
    bit          rx_random = 1'b1;

    segment_intersection uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #10 aclk = ~aclk;

    // 2-d cross product, exact at 128 bits
    function automatic logic signed [127:0] cross2(
        input logic signed [63:0] ux, uy, vx, vy);
        logic signed [127:0] a, b;
        a = ux;
        b = uy;
        return a * vy - b * vx;
    endfunction

    function automatic int sign_of(input logic signed [127:0] v);
        return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
    endfunction

    function automatic int orient(input logic signed [63:0] ax, ay, bx, by, cx, cy);
        return sign_of(cross2(bx - ax, by - ay, cx - ax, cy - ay));
    endfunction

    // division rounded toward minus infinity
    function automatic logic signed [127:0] floor_div(
        input logic signed [127:0] n, d);
        logic signed [127:0] q, r;
        if (d == 0) return 0;
        q = n / d;
        r = n % d;
        if (r != 0 && ((r < 0) != (d < 0))) q = q - 1;
        return q;
    endfunction

    function automatic segint_out_t predict_crossing(input segint_in_t s);
        logic signed [63:0] ax, ay, bx, by, cx, cy, dx, dy;
        logic signed [127:0] num, den, wx, wy;
        segint_out_t r;
        ax = s.seg1_start_x; ay = s.seg1_start_y;
        bx = s.seg1_end_x;   by = s.seg1_end_y;
        cx = s.seg2_start_x; cy = s.seg2_start_y;
        dx = s.seg2_end_x;   dy = s.seg2_end_y;
        r = '0;
        if (orient(ax, ay, bx, by, cx, cy) * orient(ax, ay, bx, by, dx, dy) < 0 &&
            orient(cx, cy, dx, dy, ax, ay) * orient(cx, cy, dx, dy, bx, by) < 0) begin
            num = cross2(dx - bx, dy - by, cx - dx, cy - dy);
            den = cross2(ax - bx, ay - by, cx - dx, cy - dy);
            wx = num * (ax - bx);
            wy = num * (ay - by);
            r.hit = 1'b1;
            r.cross_x = CW'(bx + floor_div(wx, den));
            r.cross_y = CW'(by + floor_div(wy, den));
        end
        return r;
    endfunction

    // valid drops only before a gap or when the sender goes idle
    task automatic send_segments(input segint_in_t s, input bit gaps = 1'b1);
        int wait_cycles;
        wait_cycles = gaps ? $urandom_range(0, 5) : 0;
        if (wait_cycles != 0) begin
            s_valid <= 1'b0;
            repeat (wait_cycles) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= s;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        crossing_queue.push_back(predict_crossing(s));
        @(negedge aclk);
    endtask

    // receiver side, ready drawn per result
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_ready <= 1'b0;
            end else if (rx_random) begin
                stall = $urandom_range(0, 5);
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
                m_ready <= 1'b1;
                @(posedge aclk);
                while (!m_valid && !rx_hold) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        segint_out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (crossing_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_data);
            end else begin
                exp_r = crossing_queue.pop_front();
                if (m_data.hit !== exp_r.hit || m_data.cross_x !== exp_r.cross_x ||
                    m_data.cross_y !== exp_r.cross_y) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected hit=%0d x=%0d y=%0d, got hit=%0d x=%0d y=%0d",
                                 exp_r.hit, exp_r.cross_x, exp_r.cross_y,
                                 m_data.hit, m_data.cross_x, m_data.cross_y);
                end
            end
        end
    end

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return CW'($urandom);
            1: return CW'($signed($urandom_range(0, 4000)) - 2000);
            2: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            default: return CW'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    function automatic segint_in_t make_pair(
        input int x1, y1, x2, y2, x3, y3, x4, y4);
        segint_in_t s;
        s.seg1_start_x = CW'(x1); s.seg1_start_y = CW'(y1);
        s.seg1_end_x   = CW'(x2); s.seg1_end_y   = CW'(y2);
        s.seg2_start_x = CW'(x3); s.seg2_start_y = CW'(y3);
        s.seg2_end_x   = CW'(x4); s.seg2_end_y   = CW'(y4);
        return s;
    endfunction

    // random pair, mostly built to cross about a shared point
    function automatic segint_in_t random_pair();
        segint_in_t s;
        int cx, cy, r;
        if ($urandom_range(0, 3) == 0) begin
            s = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        end else begin
            r  = $urandom_range(0, 1) ? 1000 : 4000000;
            cx = $signed($urandom_range(0, 8000000)) - 4000000;
            cy = $signed($urandom_range(0, 8000000)) - 4000000;
            s = make_pair(cx - $urandom_range(1, r), cy - $urandom_range(0, r),
                          cx + $urandom_range(1, r), cy + $urandom_range(0, r),
                          cx - $urandom_range(0, r), cy + $urandom_range(1, r),
                          cx + $urandom_range(0, r), cy - $urandom_range(1, r));
        end
        return s;
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (crossing_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic test_directed();
        int mx, mn;
        mx = 8388607; mn = -8388608;
        send_segments(make_pair(0, 0, 256, 256, 0, 256, 256, 0));
        send_segments(make_pair(mn, mn, mx, mx, mn, mx, mx, mn));
        send_segments(make_pair(mx, mn, mn, mx, mx, mx, mn, mn));
        send_segments(make_pair(0, 0, 256, 0, 128, 0, 128, 256));   // touching
        send_segments(make_pair(0, 0, 256, 0, 256, 0, 512, 256));   // endpoint shared
        send_segments(make_pair(0, 0, 512, 0, 256, 0, 768, 0));     // collinear overlap
        send_segments(make_pair(0, 0, 256, 256, 0, 10, 256, 266));  // parallel
        send_segments(make_pair(5, 5, 5, 5, 0, 0, 10, 10));         // zero length
        send_segments(make_pair(5, 5, 5, 5, 5, 5, 5, 5));
        send_segments(make_pair(0, 0, 10, 10, 100, 0, 200, 50));    // disjoint
        send_segments(make_pair(0, 0, 3, 1, 0, 1, 3, 0));           // fractional rounding
        send_segments(make_pair(-3, -1, 0, 0, -3, 0, 0, -1));
        send_segments(make_pair(mn, 0, mx, 1, 0, mn, 1, mx));
        send_segments(make_pair(-1, -1, 1, 1, -1, 1, 1, -1));
        send_segments(make_pair(mx, mx, mn, mn, mn + 1, mx, mx, mn + 1));
        send_segments('1);
        send_segments('0);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        repeat (count) send_segments(random_pair());
    endtask

    // hold results back long enough for the pipeline to fill and stall input
    task automatic test_backpressure();
        fork
            begin
                rx_hold = 1'b1;
                repeat (200) @(posedge aclk);
                rx_hold = 1'b0;
            end
            repeat (80) send_segments(random_pair(), 1'b0);
        join
        wait_drained();
    endtask

    task automatic test_full_rate();
        rx_random = 1'b0;
        repeat (100) send_segments(random_pair(), 1'b0);
        wait_drained();
        rx_random = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(300);
        wait_drained();
        test_backpressure();
        test_full_rate();
        test_random(270);
        wait_drained();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/segint_pkg.sv
rtl/segment_intersection.sv
verif/testbench.sv
